### design/wmo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the wavetable morph oscillator.
// No dependencies; imported by every module of the block.
package wmo_pkg;

  // table geometry
  localparam int TABLE_BITS      = 10;
  localparam int WAVE_BITS       = 3;
  localparam int MAX_WAVES       = 1 << WAVE_BITS;
  localparam int MEM_AW          = WAVE_BITS + TABLE_BITS;
  localparam int MEM_DEPTH       = 1 << MEM_AW;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int PHASE_W         = TABLE_BITS + PHASE_FRAC_BITS;

  // morph position in units of 1/(3*32768)
  localparam int POS_ONE       = 98304;
  localparam int POS_W         = 20;
  localparam int REM_W         = 17;
  localparam int FRAC_W        = 15;
  localparam int SETTING_W     = 13;
  localparam int SETTING_MAX   = 4096;
  localparam int RECIP3        = 43691;  // ceil(2^17 / 3)
  localparam int RECIP3_SHIFT  = 17;

  // stream payload
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 26;
  localparam int WAVES_W   = 4;

  // command codes carried in s_tuser
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MORPH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVES      = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_POS  = 6'b000010,
    S_DIV  = 6'b000100,
    S_RDA  = 6'b001000,
    S_RDB  = 6'b010000,
    S_GAIN = 6'b100000
  } wmo_state_t;

  typedef struct packed {
    logic load_wr;   // store a table word from the input beat
    logic start;     // latch sample fields
    logic step_pos;  // form clamped morph position
    logic step_div;  // split position, read lower table
    logic step_a;    // lower product, read upper table
    logic step_b;    // upper product and sum
    logic step_out;  // gain, saturate, advance phase
  } wmo_cmd_t;

endpackage
`default_nettype wire

### design/wmo_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Controller FSM for the wavetable morph oscillator.
// Depends on wmo_pkg; drives wmo_datapath through wmo_cmd_t.
module wmo_ctrl
  import wmo_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire logic     s_tuser,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  output wmo_cmd_t      cmd
);

  wmo_state_t state, state_next;
  logic       m_tvalid_next;
  logic       out_free;
  logic       in_beat;

  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid & s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_beat && s_tuser == CMD_SAMPLE) state_next = S_POS;
      S_POS:  state_next = S_DIV;
      S_DIV:  state_next = S_RDA;
      S_RDA:  state_next = S_RDB;
      S_RDB:  state_next = S_GAIN;
      S_GAIN: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load_wr  = in_beat && (s_tuser == CMD_LOAD);
    cmd.start    = in_beat && (s_tuser == CMD_SAMPLE);
    cmd.step_pos = (state == S_POS);
    cmd.step_div = (state == S_DIV);
    cmd.step_a   = (state == S_RDA);
    cmd.step_b   = (state == S_RDB);
    cmd.step_out = (state == S_GAIN) && out_free;
  end

  always_comb begin
    if (cmd.step_out) m_tvalid_next = 1'b1;
    else if (m_tready) m_tvalid_next = 1'b0;
    else m_tvalid_next = m_tvalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule
`default_nettype wire

### design/wmo_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// Datapath: config registers, table memory, phase accumulator, morph arithmetic.
// Depends on wmo_pkg; sequenced by wmo_ctrl through wmo_cmd_t.
module wmo_datapath
  import wmo_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wmo_cmd_t                  cmd,
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  output logic      [M_TDATA_W-1:0] m_tdata
);

  // input beat fields
  logic [WAVE_BITS-1:0]  in_wave;
  logic [TABLE_BITS-1:0] in_addr;
  logic [15:0]           in_value;
  logic [15:0]           in_amp;
  logic [15:0]           in_mod;

  assign in_wave  = s_tdata[2:0];
  assign in_addr  = s_tdata[12:3];
  assign in_value = s_tdata[28:13];
  assign in_amp   = s_tdata[44:29];
  assign in_mod   = s_tdata[60:45];

  // configuration
  logic [PHASE_W-1:0]   phase_step;
  logic [SETTING_W-1:0] morph_setting;
  logic [WAVES_W-1:0]   waves_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= '0;
      morph_setting <= '0;
      waves_in_use  <= WAVES_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PHASE_STEP: phase_step    <= cfg_data[PHASE_W-1:0];
        REG_MORPH:      morph_setting <= cfg_data[SETTING_W-1:0];
        REG_WAVES:      waves_in_use  <= cfg_data[WAVES_W-1:0];
        default: ;
      endcase
    end
  end

  // phase accumulator wraps at the table span by its width
  logic [PHASE_W-1:0]    phase_acc;
  logic [TABLE_BITS-1:0] pos;
  assign pos = phase_acc[PHASE_W-1 -: TABLE_BITS];

  always_ff @(posedge clk) begin
    if (rst) phase_acc <= '0;
    else if (cmd.step_out) phase_acc <= phase_acc + phase_step;
  end

  // sample operands
  logic        [15:0] amp_q;
  logic signed [15:0] mod_q;
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      amp_q <= in_amp;
      mod_q <= $signed(in_mod);
    end
  end

  // morph position: setting*24*w + mod*w, clamped to 0..w*POS_ONE
  logic [WAVE_BITS-1:0] wm1;
  logic [SETTING_W-1:0] setting_c;
  logic [16:0]          sett24;
  logic [POS_W-1:0]     base;
  logic signed [POS_W-1:0] modw;
  logic signed [POS_W+1:0] t_c;
  logic [4:0]           w_x3;
  logic [POS_W-1:0]     hi_c;
  logic [POS_W-1:0]     t_q;

  always_comb begin
    if (waves_in_use == '0) wm1 = '0;
    else if (waves_in_use > WAVES_W'(MAX_WAVES)) wm1 = WAVE_BITS'(MAX_WAVES - 1);
    else wm1 = WAVE_BITS'(waves_in_use - 1'b1);
    setting_c = (morph_setting > SETTING_W'(SETTING_MAX)) ? SETTING_W'(SETTING_MAX)
                                                          : morph_setting;
    sett24 = {setting_c, 4'b0} + {1'b0, setting_c, 3'b0};
    base   = POS_W'(sett24 * wm1);
    modw   = POS_W'(mod_q * $signed({1'b0, wm1}));
    t_c    = $signed({2'b0, base}) + (POS_W+2)'(modw);
    w_x3   = 5'(wm1 * 2'd3);
    hi_c   = {w_x3, 15'b0};
  end

  always_ff @(posedge clk) begin
    if (cmd.step_pos) begin
      if (t_c < 0) t_q <= '0;
      else if (t_c > $signed({2'b0, hi_c})) t_q <= hi_c;
      else t_q <= t_c[POS_W-1:0];
    end
  end

  // integer wave and fraction; /3 by reciprocal, exact for rem < 2^17
  logic [WAVE_BITS-1:0] idx_c, idx_q;
  logic [REM_W-1:0]     rem_c;
  logic [32:0]          frac_prod;
  logic [FRAC_W-1:0]    f_q;

  always_comb begin
    idx_c = '0;
    for (int k = 1; k < MAX_WAVES; k++) begin
      if (t_q >= POS_W'(k * POS_ONE)) idx_c = WAVE_BITS'(k);
    end
    rem_c     = REM_W'(t_q - POS_W'(idx_c * POS_ONE));
    frac_prod = 33'(rem_c) * 33'(RECIP3);
  end

  always_ff @(posedge clk) begin
    if (cmd.step_div) begin
      idx_q <= idx_c;
      f_q   <= frac_prod[RECIP3_SHIFT +: FRAC_W];
    end
  end

  // table memory, one write and one registered read port
  logic [15:0]       mem [MEM_DEPTH];
  logic [MEM_AW-1:0] rd_addr;
  logic [15:0]       rd_data;

  assign rd_addr = cmd.step_div ? {idx_c, pos}
                                : {WAVE_BITS'(idx_q + 1'b1), pos};

  always_ff @(posedge clk) begin
    if (cmd.load_wr) mem[{in_wave, in_addr}] <= in_value;
    rd_data <= mem[rd_addr];
  end

  // crossfade: a*(32768-f) + b*f; the upper word is ignored at zero fraction
  logic [16:0]        wa;
  logic signed [33:0] pa_c;
  logic signed [31:0] pb_c;
  logic signed [31:0] prod_a_q;
  logic signed [31:0] mix_q;

  always_comb begin
    wa   = 17'd32768 - {2'b0, f_q};
    pa_c = 34'($signed(rd_data) * $signed({1'b0, wa}));
    pb_c = 32'($signed(rd_data) * $signed({1'b0, f_q}));
  end

  always_ff @(posedge clk) begin
    if (cmd.step_a) prod_a_q <= pa_c[31:0];
    if (cmd.step_b) mix_q <= prod_a_q + ((f_q == '0) ? 32'sd0 : pb_c);
  end

  // gain with round half up, then saturate
  logic signed [48:0] g_c, r_c;
  logic signed [18:0] y_c;

  always_comb begin
    g_c = 49'(mix_q * $signed({1'b0, amp_q}));
    r_c = g_c + 49'sd536870912;
    y_c = r_c[48:30];
  end

  always_ff @(posedge clk) begin
    if (cmd.step_out) begin
      if (y_c > 19'sd32767) m_tdata <= 16'h7FFF;
      else if (y_c < -19'sd32768) m_tdata <= 16'h8000;
      else m_tdata <= y_c[15:0];
    end
  end

endmodule
`default_nettype wire

### design/wavetable_morph_oscillator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Wavetable morph oscillator, top level.
// Depends on wmo_pkg, wmo_ctrl and wmo_datapath.
//
// Usage:
//  - s_* channel: one beat per item. s_tuser = 0 loads one table word
//    (wave_number, table_address, table_value); s_tuser = 1 asks for a sample
//    using amplitude and modulation. Loads are taken back to back while idle.
//  - A sample beat walks the FSM through position, split/lower read, upper
//    read, crossfade and gain; the result then shows on m_tvalid, and the
//    next beat is taken only after the FSM is back in idle, so a sample is
//    finished before the next is accepted. The single table read port (two
//    reads per sample) and the chain of registered products set this pace.
//  - m_* channel: m_tdata holds the result in an output register. While the
//    receiver stalls the block still takes the next beat and computes up to
//    the gain step, where it waits until the output register is free.
//  - cfg_*: register writes, always ready; write only while the block is idle.
//  - rst: clears the FSM, output valid, phase accumulator and config registers
//    (waves_in_use = 1). The table memory is not cleared; load before use.
module wavetable_morph_oscillator_unit
  import wmo_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // [2:0] wave_number, [12:3] table_address, [28:13] table_value,
  // [44:29] amplitude, [60:45] modulation, [63:61] zero
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // [0] command
  input  wire logic                 s_tuser,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [15:0] sample
  output logic      [M_TDATA_W-1:0] m_tdata,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  wmo_cmd_t cmd;

  assign cfg_ready = 1'b1;

  wmo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  wmo_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire

### design/wmo_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the wavetable morph oscillator, with its bind.
// Depends on wmo_pkg and wavetable_morph_oscillator_unit.
module wmo_checker
  import wmo_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 s_tuser,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // a sample beat occupies the engine
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_SAMPLE |=> !s_tready)
    else $error("input taken while a sample is in progress");

  // loads stream at one per cycle
  a_load_stream: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_LOAD |=> s_tready)
    else $error("load stalled the input");

  // a sample beat taken while the output is empty does not raise the result straight away
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_SAMPLE && !m_tvalid |=> !m_tvalid)
    else $error("result appeared too early");

  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind wavetable_morph_oscillator_unit wmo_checker u_wmo_checker (.*);
`default_nettype wire
